// ===== hw/rtl/bounded_fifo_window_mean_assert.svh =====
// Assertion macros for the window mean block, clocked on i_clk, off in reset.
`ifndef BOUNDED_FIFO_WINDOW_MEAN_ASSERT_SVH
`define BOUNDED_FIFO_WINDOW_MEAN_ASSERT_SVH

// Check the consequent in the same cycle as the antecedent.
`define BFWM_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("bfwm assertion failed");

// Check the consequent in the cycle after the antecedent.
`define BFWM_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("bfwm assertion failed");

`endif

// ===== hw/rtl/bfwm_pkg.sv =====
`timescale 1ns / 1ps
package bfwm_pkg;
    localparam int HW     = 12;
    localparam int QB     = 12;
    localparam int STEP_W = $clog2(QB);

    typedef struct packed {
        logic load;
        logic rd_head;
        logic pop;
        logic push;
        logic div_init;
        logic div_step;
        logic out_load;
        logic is_remove;
        logic err;
    } t_dp_cmd;

    typedef struct packed {
        logic count_zero;
        logic full;
        logic out_busy;
    } t_dp_stat;
endpackage

// ===== hw/rtl/bfwm_in_if.sv =====
`timescale 1ns / 1ps
interface bfwm_in_if;
    logic                      valid;
    logic                      ready;
    logic                      cmd;
    logic [bfwm_pkg::HW-1:0]   height_in;

    modport source (output valid, output cmd, output height_in, input ready);
    modport sink   (input valid, input cmd, input height_in, output ready);
endinterface

// ===== hw/rtl/bfwm_out_if.sv =====
`timescale 1ns / 1ps
interface bfwm_out_if;
    logic                      valid;
    logic                      ready;
    logic [bfwm_pkg::HW-1:0]   mean_height;
    logic [bfwm_pkg::HW-1:0]   removed_height;
    logic                      empty_error;

    modport source (output valid, output mean_height, output removed_height,
                    output empty_error, input ready);
    modport sink   (input valid, input mean_height, input removed_height,
                    input empty_error, output ready);
endinterface

// ===== hw/rtl/bfwm_ctl.sv =====
`timescale 1ns / 1ps
module bfwm_ctl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic               i_cmd,
    input  bfwm_pkg::t_dp_stat i_stat,
    output logic               o_in_ready,
    output bfwm_pkg::t_dp_cmd  o_cmd
);
    import bfwm_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_POP,
        S_PUSH,
        S_DIVI,
        S_DIV,
        S_FIN
    } t_state;

    t_state              r_state;
    logic                r_is_remove;
    logic                r_err;
    logic [STEP_W-1:0]   r_step;
    logic                w_accept;

    assign w_accept   = i_in_valid && (r_state == S_IDLE);
    assign o_in_ready = (r_state == S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_is_remove <= 1'b0;
            r_err       <= 1'b0;
            r_step      <= '0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_is_remove <= i_cmd;
                        r_err       <= i_cmd && i_stat.count_zero;
                        if (i_cmd) begin
                            r_state <= i_stat.count_zero ? S_FIN : S_READ;
                        end else begin
                            r_state <= i_stat.full ? S_READ : S_PUSH;
                        end
                    end
                end
                S_READ: r_state <= S_POP;
                S_POP:  r_state <= r_is_remove ? S_FIN : S_PUSH;
                S_PUSH: r_state <= S_DIVI;
                S_DIVI: begin
                    r_step  <= STEP_W'(QB - 1);
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    if (r_step == '0) begin
                        r_state <= S_FIN;
                    end else begin
                        r_step <= r_step - 1'b1;
                    end
                end
                S_FIN: begin
                    if (!i_stat.out_busy) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    always_comb begin
        o_cmd           = '0;
        o_cmd.load      = w_accept;
        o_cmd.rd_head   = (r_state == S_READ);
        o_cmd.pop       = (r_state == S_POP);
        o_cmd.push      = (r_state == S_PUSH);
        o_cmd.div_init  = (r_state == S_DIVI);
        o_cmd.div_step  = (r_state == S_DIV);
        o_cmd.out_load  = (r_state == S_FIN) && !i_stat.out_busy;
        o_cmd.is_remove = r_is_remove;
        o_cmd.err       = r_err;
    end
endmodule

// ===== hw/rtl/bfwm_dp.sv =====
`timescale 1ns / 1ps
module bfwm_dp #(
    parameter int DEPTH = 5
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic [bfwm_pkg::HW-1:0] i_height,
    input  bfwm_pkg::t_dp_cmd       i_cmd,
    output bfwm_pkg::t_dp_stat      o_stat,
    bfwm_out_if.source              o_out
);
    import bfwm_pkg::*;

    localparam int CW = $clog2(DEPTH + 1);
    localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int TW = CW + 1;
    localparam int SW = HW + CW;
    localparam int NW = SW + 2;

    logic [HW-1:0] r_mem [DEPTH];
    logic [HW-1:0] r_rdata;
    logic [HW-1:0] r_h;
    logic [HW-1:0] r_pop_h;
    logic [IW-1:0] r_head;
    logic [CW-1:0] r_count;
    logic [SW-1:0] r_sum;
    logic [NW-1:0] r_rem;
    logic [NW-1:0] r_dsh;
    logic [QB-1:0] r_quo;
    logic          r_o_valid;
    logic [HW-1:0] r_o_mean;
    logic [HW-1:0] r_o_rem;
    logic          r_o_err;

    logic [TW-1:0] w_tsum;
    logic [TW-1:0] w_twrap;
    logic [IW-1:0] w_tail;
    logic [IW-1:0] n_head;
    logic          w_ge;

    assign w_tsum  = TW'(r_head) + TW'(r_count);
    assign w_twrap = (w_tsum >= TW'(DEPTH)) ? (w_tsum - TW'(DEPTH)) : w_tsum;
    assign w_tail  = w_twrap[IW-1:0];
    assign n_head  = (r_head == IW'(DEPTH - 1)) ? '0 : (r_head + 1'b1);
    assign w_ge    = (r_rem >= r_dsh);

    always_ff @(posedge i_clk) begin
        if (i_cmd.push) begin
            r_mem[w_tail] <= r_h;
        end
        if (i_cmd.rd_head) begin
            r_rdata <= r_mem[r_head];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head    <= '0;
            r_count   <= '0;
            r_sum     <= '0;
            r_o_valid <= 1'b0;
        end else begin
            if (i_cmd.pop) begin
                r_head  <= n_head;
                r_count <= r_count - 1'b1;
                r_sum   <= r_sum - SW'(r_rdata);
            end else if (i_cmd.push) begin
                r_count <= r_count + 1'b1;
                r_sum   <= r_sum + SW'(r_h);
            end
            if (i_cmd.out_load) begin
                r_o_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_h <= i_height;
        end
        if (i_cmd.pop) begin
            r_pop_h <= r_rdata;
        end
        if (i_cmd.div_init) begin
            r_rem <= NW'({r_sum, 1'b0}) + NW'(r_count);
            r_dsh <= NW'({r_count, 1'b0}) << (QB - 1);
            r_quo <= '0;
        end else if (i_cmd.div_step) begin
            if (w_ge) begin
                r_rem <= r_rem - r_dsh;
            end
            r_quo <= {r_quo[QB-2:0], w_ge};
            r_dsh <= r_dsh >> 1;
        end
        if (i_cmd.out_load) begin
            r_o_mean <= i_cmd.is_remove ? '0 : r_quo;
            r_o_rem  <= (i_cmd.is_remove && !i_cmd.err) ? r_pop_h : '0;
            r_o_err  <= i_cmd.err;
        end
    end

    assign o_stat.count_zero = (r_count == '0);
    assign o_stat.full       = (r_count == CW'(DEPTH));
    assign o_stat.out_busy   = r_o_valid && !o_out.ready;

    assign o_out.valid          = r_o_valid;
    assign o_out.mean_height    = r_o_mean;
    assign o_out.removed_height = r_o_rem;
    assign o_out.empty_error    = r_o_err;
endmodule

// ===== hw/rtl/bounded_fifo_window_mean.sv =====
// Insert: push, divider init, serial divide, then load the result; a full window reads and pops the head first.
// One transaction at a time; the 12-step serial divider sets the insert time, and a new command is
// accepted only after the result has been loaded into the output register, which waits while it is busy.
// Remove: read and pop the head, then load the result; a remove on an empty window goes straight to loading the error.
// Synchronous active-low reset empties the window; store contents are left as they are.
`timescale 1ns / 1ps
`include "bounded_fifo_window_mean_assert.svh"
module bounded_fifo_window_mean #(
    parameter int DEPTH = 5
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    bfwm_in_if.sink     i_in,
    bfwm_out_if.source  o_out
);
    import bfwm_pkg::*;

    t_dp_cmd  w_cmd;
    t_dp_stat w_stat;
    logic     w_in_ready;

    assign i_in.ready = w_in_ready;

    bfwm_ctl u_ctl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .i_cmd      (i_in.cmd),
        .i_stat     (w_stat),
        .o_in_ready (w_in_ready),
        .o_cmd      (w_cmd)
    );

    bfwm_dp #(
        .DEPTH (DEPTH)
    ) u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_height (i_in.height_in),
        .i_cmd    (w_cmd),
        .o_stat   (w_stat),
        .o_out    (o_out)
    );

    `BFWM_ASSERT_SAME(a_err_zero, o_out.valid && o_out.empty_error, o_out.mean_height == '0 && o_out.removed_height == '0)
    `BFWM_ASSERT_NEXT(a_busy_after_accept, i_in.valid && i_in.ready, !i_in.ready)
    `BFWM_ASSERT_SAME(a_status_sane, 1'b1, !(w_stat.full && w_stat.count_zero))
    `BFWM_ASSERT_NEXT(a_out_loaded, w_cmd.out_load, o_out.valid)
endmodule
